// ===== sv/cpre_pkg.sv =====
// Shared types, widths and constants of the capture-period speed estimator.
// Used by every module of the block; depends on nothing.
package cpre_pkg;

  // Field and register widths
  localparam int unsigned TIMER_W    = 30;
  localparam int unsigned PRE_W      = 16;
  localparam int unsigned PPT_W      = 16;
  localparam int unsigned RAD_W      = 16;
  localparam int unsigned PERIOD_W   = 16;
  localparam int unsigned RES_W      = 32;
  localparam int unsigned SUM_W      = 32;
  localparam int unsigned NUM_W      = 64;
  localparam int unsigned DEN_W      = 71;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 30;

  // Default ring depth and queue size
  localparam int unsigned DEF_RING_DEPTH = 8;
  localparam int unsigned QUEUE_DEPTH    = 2;

  // Register reset values
  localparam logic [TIMER_W-1:0] TIMER_RST = TIMER_W'(1000000);
  localparam logic [PRE_W-1:0]   PRE_RST   = '0;
  localparam logic [PPT_W-1:0]   PPT_RST   = PPT_W'(1);
  localparam logic [RAD_W-1:0]   RAD_RST   = '0;

  // Numerator scales: 60 s/min and 2*pi (710/113), both in Q.8
  localparam logic [NUM_W-1:0] RPM_SCALE  = NUM_W'(60 * 256);
  localparam logic [NUM_W-1:0] VEL_SCALE  = NUM_W'(710 * 256);
  localparam logic [DEN_W-1:0] TWO_PI_DEN = DEN_W'(113);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMER_CLK = 2'd0,
    CFG_PRESCALE  = 2'd1,
    CFG_PULSES    = 2'd2,
    CFG_RADIUS    = 2'd3
  } cfg_idx_e;

  typedef enum logic [0:0] {
    CMD_CAPTURE  = 1'b0,
    CMD_OVERFLOW = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_READ,
    F_MUL,
    F_FIX
  } front_state_e;

  typedef enum logic [3:0] {
    B_IDLE,
    B_CHECK,
    B_MUL1,
    B_MUL2,
    B_DIV_RPM,
    B_WAIT_RPM,
    B_DIV_VEL,
    B_WAIT_VEL,
    B_DONE
  } back_state_e;

  typedef struct packed {
    logic [TIMER_W-1:0] clk_hz;
    logic [PRE_W-1:0]   prescale;
    logic [PPT_W-1:0]   pulses;
    logic [RAD_W-1:0]   radius;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic             sat;
    logic [RES_W-1:0] quo;
  } div_rsp_t;

endpackage

// ===== sv/cpre_front.sv =====
// Front end: accepts events, updates the period ring and running sum, forms the mean.
// Depends on cpre_pkg; feeds the mean queue.
module cpre_front #(
  parameter int unsigned RING_DEPTH = cpre_pkg::DEF_RING_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          cmd_i,
  input  logic [cpre_pkg::PERIOD_W-1:0] period_ticks_i,
  output logic                          q_push_o,
  output logic [cpre_pkg::SUM_W-1:0]    q_mean_o,
  input  logic                          q_full_i
);
  import cpre_pkg::*;

  localparam int unsigned SLOT_W  = $clog2(RING_DEPTH);
  localparam int unsigned DEPTH_W = SLOT_W + 1;
  localparam int unsigned SHIFT   = SUM_W + SLOT_W;
  localparam int unsigned RECIP_W = SUM_W + 1;
  localparam int unsigned PROD_W  = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << SHIFT) / RING_DEPTH);
  localparam logic [SUM_W-1:0]   MARK  = SUM_W'((64'd1 << SUM_W) / RING_DEPTH);
  localparam logic [DEPTH_W-1:0] DVAL  = DEPTH_W'(RING_DEPTH);
  localparam logic [SLOT_W-1:0]  LAST  = SLOT_W'(RING_DEPTH - 1);

  front_state_e st_q, st_d;
  logic [SUM_W-1:0]      ring_mem [RING_DEPTH];
  logic [RING_DEPTH-1:0] valid_q, valid_d;
  logic [SLOT_W-1:0]     slot_q, slot_d;
  logic [SUM_W-1:0]      sum_q, sum_d;
  logic [SUM_W-1:0]      value_q, value_d;
  logic [SUM_W-1:0]      old_q;
  logic [PROD_W-1:0]     prod_q, prod_d;
  logic                  mem_re, mem_we;
  logic [SUM_W-1:0]      est, rem;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= F_IDLE;
      valid_q <= '0;
      slot_q  <= '0;
      sum_q   <= '0;
    end else begin
      st_q    <= st_d;
      valid_q <= valid_d;
      slot_q  <= slot_d;
      sum_q   <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    prod_q  <= prod_d;
  end

  // Ring storage: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[slot_q] <= value_q;
    end
    if (mem_re) begin
      old_q <= ring_mem[slot_q];
    end
  end

  // Mean by reciprocal; the estimate is low by at most one
  assign est      = SUM_W'(prod_q >> SHIFT);
  assign rem      = sum_q - SUM_W'(est * DVAL);
  assign q_mean_o = (rem >= SUM_W'(RING_DEPTH)) ? SUM_W'(est + 1'b1) : est;

  always_comb begin
    logic [SUM_W-1:0] old;
    old        = '0;
    st_d       = st_q;
    valid_d    = valid_q;
    slot_d     = slot_q;
    sum_d      = sum_q;
    value_d    = value_q;
    prod_d     = prod_q;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    q_push_o   = 1'b0;
    in_stall_o = (st_q != F_IDLE);
    unique case (st_q)
      F_IDLE: begin
        if (in_valid_i) begin
          mem_re  = 1'b1;
          value_d = (cmd_i == CMD_OVERFLOW) ? MARK : SUM_W'(period_ticks_i);
          st_d    = F_READ;
        end
      end
      F_READ: begin
        // Never-written slots read as zero
        old             = valid_q[slot_q] ? old_q : '0;
        sum_d           = sum_q - old + value_q;
        mem_we          = 1'b1;
        valid_d[slot_q] = 1'b1;
        slot_d          = (slot_q == LAST) ? '0 : SLOT_W'(slot_q + 1'b1);
        st_d            = F_MUL;
      end
      F_MUL: begin
        prod_d = PROD_W'(sum_q) * PROD_W'(RECIP);
        st_d   = F_FIX;
      end
      F_FIX: begin
        if (!q_full_i) begin
          q_push_o = 1'b1;
          st_d     = F_IDLE;
        end
      end
    endcase
  end

endmodule

// ===== sv/cpre_queue.sv =====
// Short FIFO of mean periods between the front and back ends.
// Depends on cpre_pkg for width and depth.
module cpre_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [cpre_pkg::SUM_W-1:0] push_data_i,
  output logic                       full_o,
  input  logic                       pop_i,
  output logic [cpre_pkg::SUM_W-1:0] pop_data_o,
  output logic                       empty_o
);
  import cpre_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  logic [SUM_W-1:0] entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_LAST) ? '0 : PTR_W'(wr_q + 1'b1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_LAST) ? '0 : PTR_W'(rd_q + 1'b1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= CNT_W'(cnt_q + 1'b1);
      end else if (pop_i && !push_i) begin
        cnt_q <= CNT_W'(cnt_q - 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= push_data_i;
    end
  end

  assign pop_data_o = entry_q[rd_q];
  assign full_o     = (cnt_q == CNT_FULL);
  assign empty_o    = (cnt_q == '0);

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q != CNT_FULL))
    else $error("mean queue pushed while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (cnt_q != '0))
    else $error("mean queue popped while empty");

endmodule

// ===== sv/cpre_div.sv =====
// Iterative restoring divider with a 32-bit quotient and saturation detect.
// Depends on cpre_pkg for widths and the request/response structs.
module cpre_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cpre_pkg::div_req_t req_i,
  output cpre_pkg::div_rsp_t rsp_o
);
  import cpre_pkg::*;

  localparam int unsigned HI_W  = NUM_W - RES_W;
  localparam int unsigned CNT_W = $clog2(RES_W + 1);

  logic             busy_q, done_q, sat_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DEN_W-1:0] den_q, rem_q;
  logic [RES_W-1:0] lo_q;
  logic [HI_W-1:0]  hi;
  logic             hi_sat;
  logic [DEN_W:0]   trial;
  logic             ge;

  assign hi     = req_i.num[NUM_W-1:RES_W];
  // Quotient needs more than 32 bits exactly when the high half reaches the divisor
  assign hi_sat = (DEN_W'(hi) >= req_i.den);
  assign trial  = {rem_q, lo_q[RES_W-1]};
  assign ge     = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= hi_sat ? '0 : CNT_W'(RES_W);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= CNT_W'(cnt_q - 1'b1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      sat_q <= hi_sat;
      den_q <= req_i.den;
      rem_q <= DEN_W'(hi);
      lo_q  <= req_i.num[RES_W-1:0];
    end else if (busy_q && (cnt_q != '0)) begin
      // Shift one numerator bit in, one quotient bit out
      rem_q <= ge ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
      lo_q  <= {lo_q[RES_W-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.sat  = sat_q;
  assign rsp_o.quo  = sat_q ? '1 : lo_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider flagged done while still busy");

endmodule

// ===== sv/cpre_back.sv =====
// Back end: turns a mean period into rpm and surface speed with one shared divider.
// Depends on cpre_pkg and cpre_div; drives the result register.
module cpre_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cpre_pkg::cfg_t             cfg_i,
  input  logic                       q_empty_i,
  output logic                       q_pop_o,
  input  logic [cpre_pkg::SUM_W-1:0] q_mean_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [cpre_pkg::RES_W-1:0] rpm_fixed_o,
  output logic [cpre_pkg::RES_W-1:0] speed_mm_per_s_o,
  output logic                       saturated_o
);
  import cpre_pkg::*;

  localparam int unsigned PP_W = PRE_W + 1 + PPT_W;
  localparam int unsigned RF_W = RAD_W + TIMER_W;

  back_state_e st_q, st_d;
  logic [SUM_W-1:0] mean_q, mean_d;
  logic [PP_W-1:0]  pp_q, pp_d;
  logic [RF_W-1:0]  rf_q, rf_d;
  logic [NUM_W-1:0] den_q, den_d;
  logic [DEN_W-1:0] den113_q, den113_d;
  logic [NUM_W-1:0] nrpm_q, nrpm_d;
  logic [NUM_W-1:0] nvel_q, nvel_d;
  logic [RES_W-1:0] rpm_q, rpm_d, vel_q, vel_d;
  logic             sat_q, sat_d;
  logic             out_valid_q, out_valid_d;
  logic [RES_W-1:0] out_rpm_q, out_rpm_d, out_vel_q, out_vel_d;
  logic             out_sat_q, out_sat_d;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  cpre_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mean_q    <= mean_d;
    pp_q      <= pp_d;
    rf_q      <= rf_d;
    den_q     <= den_d;
    den113_q  <= den113_d;
    nrpm_q    <= nrpm_d;
    nvel_q    <= nvel_d;
    rpm_q     <= rpm_d;
    vel_q     <= vel_d;
    sat_q     <= sat_d;
    out_rpm_q <= out_rpm_d;
    out_vel_q <= out_vel_d;
    out_sat_q <= out_sat_d;
  end

  always_comb begin
    st_d          = st_q;
    mean_d        = mean_q;
    pp_d          = pp_q;
    rf_d          = rf_q;
    den_d         = den_q;
    den113_d      = den113_q;
    nrpm_d        = nrpm_q;
    nvel_d        = nvel_q;
    rpm_d         = rpm_q;
    vel_d         = vel_q;
    sat_d         = sat_q;
    out_rpm_d     = out_rpm_q;
    out_vel_d     = out_vel_q;
    out_sat_d     = out_sat_q;
    out_valid_d   = out_valid_q && out_stall_i;
    q_pop_o       = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = nrpm_q;
    div_req.den   = DEN_W'(den_q);
    unique case (st_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          mean_d  = q_mean_i;
          st_d    = B_CHECK;
        end
      end
      B_CHECK: begin
        if ((mean_q == '0) || (cfg_i.pulses == '0)) begin
          rpm_d = '0;
          vel_d = '0;
          sat_d = 1'b0;
          st_d  = B_DONE;
        end else begin
          pp_d = PP_W'(PP_W'(cfg_i.prescale) + 1'b1) * PP_W'(cfg_i.pulses);
          rf_d = RF_W'(cfg_i.radius) * RF_W'(cfg_i.clk_hz);
          st_d = B_MUL1;
        end
      end
      B_MUL1: begin
        den_d  = NUM_W'(pp_q) * NUM_W'(mean_q);
        nrpm_d = NUM_W'(cfg_i.clk_hz) * RPM_SCALE;
        nvel_d = NUM_W'(rf_q) * VEL_SCALE;
        st_d   = B_MUL2;
      end
      B_MUL2: begin
        den113_d = DEN_W'(den_q) * TWO_PI_DEN;
        st_d     = B_DIV_RPM;
      end
      B_DIV_RPM: begin
        div_req.start = 1'b1;
        st_d          = B_WAIT_RPM;
      end
      B_WAIT_RPM: begin
        if (div_rsp.done) begin
          rpm_d = div_rsp.quo;
          sat_d = div_rsp.sat;
          st_d  = B_DIV_VEL;
        end
      end
      B_DIV_VEL: begin
        div_req.start = 1'b1;
        div_req.num   = nvel_q;
        div_req.den   = den113_q;
        st_d          = B_WAIT_VEL;
      end
      B_WAIT_VEL: begin
        if (div_rsp.done) begin
          vel_d = div_rsp.quo;
          sat_d = sat_q | div_rsp.sat;
          st_d  = B_DONE;
        end
      end
      B_DONE: begin
        // Load the result register once it is free or being emptied
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_rpm_d   = rpm_q;
          out_vel_d   = vel_q;
          out_sat_d   = sat_q;
          st_d        = B_IDLE;
        end
      end
      default: begin
        st_d = B_IDLE;
      end
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign rpm_fixed_o      = out_rpm_q;
  assign speed_mm_per_s_o = out_vel_q;
  assign saturated_o      = out_sat_q;

  a_sat_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_sat_q) |-> ((out_rpm_q == '1) || (out_vel_q == '1)))
    else $error("saturation flag set without a clamped output");

endmodule

// ===== sv/capture_period_rpm_estimator.sv =====
// An event passes the front end (READ, MUL, FIX) into the queue; the back end pops it,
// checks, multiplies, divides for rpm then for speed, and loads the result register.
// The back end takes one mean at a time, using the shared divider twice on it; a zero
// mean or zero pulses per turn skips it; events enter until the queue fills. Reset:
// registers take their defaults, the ring reads as zero at once through per-slot valid
// bits, so no clearing pass is needed. Up to two means queue between the halves.
module capture_period_rpm_estimator #(
  parameter int unsigned RING_DEPTH = cpre_pkg::DEF_RING_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cpre_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cpre_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            cmd_i,
  input  logic [cpre_pkg::PERIOD_W-1:0]   period_ticks_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [cpre_pkg::RES_W-1:0]      rpm_fixed_o,
  output logic [cpre_pkg::RES_W-1:0]      speed_mm_per_s_o,
  output logic                            saturated_o
);
  import cpre_pkg::*;

  cfg_t             cfg_q;
  logic             q_push, q_full, q_pop, q_empty;
  logic [SUM_W-1:0] q_wdata, q_rdata;

  // Configuration registers; the user must write only while the block is idle, since the
  // block does not enforce it and the back end reads them directly with no shadow copy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clk_hz   <= TIMER_RST;
      cfg_q.prescale <= PRE_RST;
      cfg_q.pulses   <= PPT_RST;
      cfg_q.radius   <= RAD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_TIMER_CLK: cfg_q.clk_hz   <= cfg_wdata_i[TIMER_W-1:0];
        CFG_PRESCALE:  cfg_q.prescale <= cfg_wdata_i[PRE_W-1:0];
        CFG_PULSES:    cfg_q.pulses   <= cfg_wdata_i[PPT_W-1:0];
        CFG_RADIUS:    cfg_q.radius   <= cfg_wdata_i[RAD_W-1:0];
      endcase
    end
  end

  // Front end: ring of periods, running sum and the mean
  cpre_front #(
    .RING_DEPTH (RING_DEPTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .period_ticks_i (period_ticks_i),
    .q_push_o       (q_push),
    .q_mean_o       (q_wdata),
    .q_full_i       (q_full)
  );

  // Decouple: the front end keeps taking events while the divider works, until the queue is full
  cpre_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_rdata),
    .empty_o     (q_empty)
  );

  // Back end: speed arithmetic and the result register
  cpre_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .q_empty_i        (q_empty),
    .q_pop_o          (q_pop),
    .q_mean_i         (q_rdata),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .rpm_fixed_o      (rpm_fixed_o),
    .speed_mm_per_s_o (speed_mm_per_s_o),
    .saturated_o      (saturated_o)
  );

endmodule
